>>> design/c8fd_pkg.sv
// c8fd_pkg: types, codes and the CRC-8 byte update for the framed message decoder.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package c8fd_pkg;

	localparam int POS_W      = 4;
	localparam int BYTE_W     = 8;
	localparam int PAYLOAD_W  = 64;
	localparam int LANES      = PAYLOAD_W / BYTE_W;
	localparam int LANE_IDX_W = $clog2(LANES);
	localparam int CFG_IDX_W  = 1;

	typedef logic [1:0]           status_t;
	typedef logic [BYTE_W-1:0]    byte_t;
	typedef logic [PAYLOAD_W-1:0] payload_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam status_t STATUS_VALID    = 2'd0;
	localparam status_t STATUS_BOUNDARY = 2'd1;
	localparam status_t STATUS_CHECKSUM = 2'd2;

	localparam cfg_idx_t REG_START_MARKER = 1'd0;
	localparam cfg_idx_t REG_END_MARKER   = 1'd1;

	localparam byte_t CRC_POLY = 8'h8c;
	localparam byte_t CRC_INIT = 8'hff;

	// reflected CRC-8, one byte
	function automatic byte_t crc8_update(input byte_t crc, input byte_t data);
		byte_t c;
		c = crc ^ data;
		for (int b = 0; b < BYTE_W; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> design/c8fd_if.sv
// c8fd_in_if / c8fd_out_if: valid/ready channels for wire bytes and frame results.
// Depends on c8fd_pkg.
`default_nettype none

interface c8fd_in_if;
	logic              valid;
	logic              ready;
	c8fd_pkg::byte_t   wire_byte;
	logic              frame_begin;

	modport source(output valid, wire_byte, frame_begin, input ready);
	modport sink(input valid, wire_byte, frame_begin, output ready);
endinterface

interface c8fd_out_if;
	logic               valid;
	logic               ready;
	c8fd_pkg::status_t  status;
	c8fd_pkg::byte_t    frame_type;
	c8fd_pkg::payload_t payload_bytes;

	modport source(output valid, status, frame_type, payload_bytes, input ready);
	modport sink(input valid, status, frame_type, payload_bytes, output ready);
endinterface

`default_nettype wire

>>> design/crc8_frame_decoder.sv
// crc8_frame_decoder: byte-serial framed message receiver with CRC-8 check.
// Result: the result word is registered and valid in the cycle after the end byte is accepted.
// Throughput: one wire byte per cycle; the result register stalls input only while full
// and not taken.
// Reset (arst_n low, async): position 0, CRC 0xFF, markers 0, no result pending.
// Depends on c8fd_pkg and c8fd_if.
`default_nettype none

module crc8_frame_decoder #(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire c8fd_pkg::cfg_idx_t cfg_index,
	input  wire c8fd_pkg::byte_t    cfg_wdata,
	c8fd_in_if.sink                 byte_ch,
	c8fd_out_if.source              result_ch
);

	localparam int P_W = c8fd_pkg::POS_W;
	localparam logic [P_W-1:0] POS_START = P_W'(0);
	localparam logic [P_W-1:0] POS_TYPE  = P_W'(1);
	localparam logic [P_W-1:0] POS_FIRST = P_W'(2);
	localparam logic [P_W-1:0] POS_CHECK = P_W'(PAYLOAD_BYTES + 2);
	localparam logic [P_W-1:0] POS_END   = P_W'(PAYLOAD_BYTES + 3);

	c8fd_pkg::byte_t    start_marker_q, end_marker_q;
	logic [P_W-1:0]     pos_q;
	c8fd_pkg::byte_t    crc_q;
	logic               start_good_q, chk_good_q;
	c8fd_pkg::byte_t    held_type_q;
	c8fd_pkg::payload_t held_payload_q;

	logic               res_valid_q;
	c8fd_pkg::status_t  res_status_q;
	c8fd_pkg::byte_t    res_type_q;
	c8fd_pkg::payload_t res_payload_q;

	logic               accept, is_end;
	logic [P_W-1:0]     pos_cur;
	logic [c8fd_pkg::LANE_IDX_W-1:0] lane;
	c8fd_pkg::byte_t    crc_next;
	c8fd_pkg::payload_t payload_next;
	c8fd_pkg::status_t  status_next;

	assign byte_ch.ready = !res_valid_q || result_ch.ready;
	assign accept        = byte_ch.valid && byte_ch.ready;

	assign pos_cur  = byte_ch.frame_begin ? POS_START : pos_q;
	assign lane     = c8fd_pkg::LANE_IDX_W'(pos_cur - POS_FIRST);
	assign crc_next = c8fd_pkg::crc8_update(crc_q, byte_ch.wire_byte);
	assign is_end   = (pos_cur != POS_START) && (pos_cur != POS_TYPE) &&
	                  (pos_cur >= POS_CHECK) && (pos_cur != POS_CHECK);

	always_comb begin
		payload_next = held_payload_q;
		for (int i = 0; i < c8fd_pkg::LANES; i++) begin
			if (lane == c8fd_pkg::LANE_IDX_W'(i)) begin
				payload_next[i*c8fd_pkg::BYTE_W +: c8fd_pkg::BYTE_W] =
					held_payload_q[i*c8fd_pkg::BYTE_W +: c8fd_pkg::BYTE_W] |
					byte_ch.wire_byte;
			end
		end
	end

	always_comb begin
		priority if (!start_good_q || byte_ch.wire_byte != end_marker_q) begin
			status_next = c8fd_pkg::STATUS_BOUNDARY;
		end else if (!chk_good_q) begin
			status_next = c8fd_pkg::STATUS_CHECKSUM;
		end else begin
			status_next = c8fd_pkg::STATUS_VALID;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= '0;
			end_marker_q   <= '0;
			pos_q          <= POS_START;
			crc_q          <= c8fd_pkg::CRC_INIT;
			start_good_q   <= 1'b0;
			chk_good_q     <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					c8fd_pkg::REG_START_MARKER: start_marker_q <= cfg_wdata;
					c8fd_pkg::REG_END_MARKER:   end_marker_q   <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept && is_end) begin
				res_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				res_valid_q <= 1'b0;
			end
			if (accept) begin
				priority if (pos_cur == POS_START) begin
					start_good_q <= (byte_ch.wire_byte == start_marker_q);
					crc_q        <= c8fd_pkg::CRC_INIT;
					chk_good_q   <= 1'b0;
					pos_q        <= POS_TYPE;
				end else if (pos_cur < POS_CHECK) begin
					crc_q <= crc_next;
					pos_q <= pos_cur + P_W'(1);
				end else if (pos_cur == POS_CHECK) begin
					chk_good_q <= (byte_ch.wire_byte == crc_q);
					pos_q      <= POS_END;
				end else begin
					pos_q        <= POS_START;
					crc_q        <= c8fd_pkg::CRC_INIT;
					start_good_q <= 1'b0;
					chk_good_q   <= 1'b0;
				end
			end
		end
	end

	// frame contents and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			if (pos_cur == POS_START) begin
				held_type_q    <= '0;
				held_payload_q <= '0;
			end else if (pos_cur == POS_TYPE) begin
				held_type_q <= byte_ch.wire_byte;
			end else if (pos_cur < POS_CHECK) begin
				held_payload_q <= payload_next;
			end
			if (is_end) begin
				res_status_q  <= status_next;
				res_type_q    <= (status_next == c8fd_pkg::STATUS_VALID) ? held_type_q : '0;
				res_payload_q <= (status_next == c8fd_pkg::STATUS_VALID) ?
				                 held_payload_q : '0;
			end
		end
	end

	assign result_ch.valid         = res_valid_q;
	assign result_ch.status        = res_status_q;
	assign result_ch.frame_type    = res_type_q;
	assign result_ch.payload_bytes = res_payload_q;

endmodule

`default_nettype wire

>>> design/c8fd_checker.sv
// c8fd_checker: port-level assertions for crc8_frame_decoder, bound to the top level.
// Depends on c8fd_pkg.
`default_nettype none

module c8fd_checker #(
	parameter int PAYLOAD_BYTES = 8
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire c8fd_pkg::status_t  status,
	input wire c8fd_pkg::byte_t    frame_type,
	input wire c8fd_pkg::payload_t payload_bytes
);

	localparam int USED_W = 8 * PAYLOAD_BYTES;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(frame_type) && $stable(payload_bytes))
		else $error("result word changed while stalled");

	// input stalls only behind a full, untaken result register
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without back-pressure");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == c8fd_pkg::STATUS_VALID ||
		status == c8fd_pkg::STATUS_BOUNDARY || status == c8fd_pkg::STATUS_CHECKSUM)
		else $error("undefined status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != c8fd_pkg::STATUS_VALID |->
		frame_type == '0 && payload_bytes == '0)
		else $error("error word carries data");

	a_payload_unused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (payload_bytes >> USED_W) == '0)
		else $error("payload bits beyond frame length set");

endmodule

bind crc8_frame_decoder c8fd_checker #(
	.PAYLOAD_BYTES(PAYLOAD_BYTES)
) u_c8fd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (byte_ch.ready),
	.out_valid     (result_ch.valid),
	.out_ready     (result_ch.ready),
	.status        (result_ch.status),
	.frame_type    (result_ch.frame_type),
	.payload_bytes (result_ch.payload_bytes)
);

`default_nettype wire

>>> verif/crc8_frame_decoder_test.sv
// crc8_frame_decoder_test: drives framed messages, noise and resyncs into the decoder and
// checks every result word against an in-bench decoder model. Depends on c8fd_pkg, c8fd_if
// and crc8_frame_decoder.
`timescale 1ns / 100ps

module crc8_frame_decoder_test;
	import c8fd_pkg::*;

	localparam int FRAME_PAYLOAD = 8;
	localparam int CHECK_POS     = FRAME_PAYLOAD + 2;
	localparam int RUN_LIMIT_NS  = 6_000_000;

	typedef struct packed {
		status_t  status;
		byte_t    frame_type;
		payload_t payload;
	} frame_result_t;

	class decoded_frame_board;
		byte_t         start_mark;
		byte_t         end_mark;
		logic [3:0]    pos;
		byte_t         crc_acc;
		bit            start_ok;
		bit            check_ok;
		byte_t         type_hold;
		payload_t      payload_hold;
		frame_result_t expected_frames[$];
		int            errors;
		int            words_seen;

		function new();
			start_mark   = '0;
			end_mark     = '0;
			pos          = '0;
			crc_acc      = CRC_INIT;
			start_ok     = 1'b0;
			check_ok     = 1'b0;
			type_hold    = '0;
			payload_hold = '0;
			errors       = 0;
			words_seen   = 0;
		endfunction

		// bitwise reflected CRC-8, LSB first
		static function byte_t crc_step(byte_t crc, byte_t data);
			byte_t c;
			bit    fb;
			c = crc;
			for (int i = 0; i < BYTE_W; i++) begin
				fb = c[0] ^ data[i];
				c  = c >> 1;
				if (fb)
					c = c ^ CRC_POLY;
			end
			return c;
		endfunction

		function void set_reg(cfg_idx_t idx, byte_t val);
			case (idx)
				REG_START_MARKER: start_mark = val;
				REG_END_MARKER:   end_mark   = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction

		function void take_byte(byte_t b, bit begin_flag);
			int            p;
			frame_result_t r;
			p = begin_flag ? 0 : int'(pos);
			if (p == 0) begin
				start_ok     = (b == start_mark);
				crc_acc      = CRC_INIT;
				check_ok     = 1'b0;
				type_hold    = '0;
				payload_hold = '0;
				pos          = 4'd1;
			end else if (p == 1) begin
				type_hold = b;
				crc_acc   = crc_step(crc_acc, b);
				pos       = 4'd2;
			end else if (p < CHECK_POS) begin
				payload_hold[8*((p-2) & 7) +: 8] = b;
				crc_acc = crc_step(crc_acc, b);
				pos     = 4'(p + 1);
			end else if (p == CHECK_POS) begin
				check_ok = (b == crc_acc);
				pos      = 4'(CHECK_POS + 1);
			end else begin
				if (!start_ok || b != end_mark)
					r.status = STATUS_BOUNDARY;
				else if (!check_ok)
					r.status = STATUS_CHECKSUM;
				else
					r.status = STATUS_VALID;
				r.frame_type = (r.status == STATUS_VALID) ? type_hold : '0;
				r.payload    = (r.status == STATUS_VALID) ? payload_hold : '0;
				expected_frames.push_back(r);
				pos      = '0;
				crc_acc  = CRC_INIT;
				start_ok = 1'b0;
				check_ok = 1'b0;
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("%0t ns: ERROR %s", $time, msg);
		endtask

		task check_result(status_t st, byte_t ft, payload_t pl);
			frame_result_t e;
			words_seen++;
			if (expected_frames.size() == 0) begin
				report($sformatf("result word %0d with nothing expected", words_seen));
			end else begin
				e = expected_frames.pop_front();
				if (st !== e.status)
					report($sformatf("word %0d status %0d, want %0d",
						words_seen, st, e.status));
				if (ft !== e.frame_type)
					report($sformatf("word %0d frame_type %02h, want %02h",
						words_seen, ft, e.frame_type));
				if (pl !== e.payload)
					report($sformatf("word %0d payload %016h, want %016h",
						words_seen, pl, e.payload));
			end
		endtask
	endclass

	logic     clk;
	logic     arst_n;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	byte_t    cfg_wdata;

	c8fd_in_if  byte_if();
	c8fd_out_if res_if();

	crc8_frame_decoder #(.PAYLOAD_BYTES(FRAME_PAYLOAD)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.byte_ch(byte_if),
		.result_ch(res_if)
	);

	decoded_frame_board board;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && res_if.valid && res_if.ready)
				board.check_result(res_if.status, res_if.frame_type, res_if.payload_bytes);
		end
	end

	// all driving tasks are entered and left at a falling edge
	task send_byte(byte_t b, bit begin_flag);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			byte_if.valid <= 1'b0;
			@(negedge clk);
		end
		byte_if.valid       <= 1'b1;
		byte_if.wire_byte   <= b;
		byte_if.frame_begin <= begin_flag;
		do
			@(posedge clk);
		while (!byte_if.ready);
		board.take_byte(b, begin_flag);
		@(negedge clk);
	endtask

	task send_frame(byte_t start_b, bit begin_flag, byte_t type_b, payload_t pl,
			bit crc_ok, byte_t end_b);
		byte_t crc;
		crc = CRC_INIT;
		send_byte(start_b, begin_flag);
		send_byte(type_b, 1'b0);
		crc = decoded_frame_board::crc_step(crc, type_b);
		for (int i = 0; i < FRAME_PAYLOAD; i++) begin
			send_byte(pl[8*i +: 8], 1'b0);
			crc = decoded_frame_board::crc_step(crc, pl[8*i +: 8]);
		end
		if (!crc_ok)
			crc = crc ^ byte_t'($urandom_range(1, 255));
		send_byte(crc, 1'b0);
		send_byte(end_b, 1'b0);
	endtask

	task write_reg(cfg_idx_t idx, byte_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
		@(negedge clk);
	endtask

	task drain_results();
		byte_if.valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int    sent;
		int    n;
		byte_t st_b;
		byte_t en_b;
		byte_t marks[6][2];

		board = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START_MARKER;
		cfg_wdata = '0;
		byte_if.valid = 1'b0;
		byte_if.wire_byte = '0;
		byte_if.frame_begin = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// directed: partial frame, resync into a valid frame, then a wrong start marker
		write_reg(REG_START_MARKER, 8'h00);
		write_reg(REG_END_MARKER, 8'hff);
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_frame(8'h00, 1'b1, 8'h00, {PAYLOAD_W{1'b1}}, 1'b1, 8'hff);
		send_frame(8'hff, 1'b0, 8'hff, '0, 1'b1, 8'hff);
		drain_results();

		marks[0] = '{8'h00, 8'h00};
		marks[1] = '{8'hff, 8'hff};
		marks[2] = '{8'hff, 8'h00};
		marks[3] = '{8'h00, 8'hff};
		marks[4] = '{byte_t'($urandom), byte_t'($urandom)};
		marks[5] = '{byte_t'($urandom), byte_t'($urandom)};

		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin send_idle_pct = 11; recv_idle_pct = 82; end
				1: begin send_idle_pct = 82; recv_idle_pct = 11; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			write_reg(REG_START_MARKER, marks[ph][0]);
			write_reg(REG_END_MARKER, marks[ph][1]);
			sent = 0;
			while (sent < 100) begin
				if ($urandom_range(0, 9) < 8) begin
					st_b = ($urandom_range(0, 9) != 0) ? board.start_mark : byte_t'($urandom);
					en_b = ($urandom_range(0, 7) != 0) ? board.end_mark : byte_t'($urandom);
					send_frame(st_b, $urandom_range(0, 1), byte_t'($urandom),
						{$urandom, $urandom}, $urandom_range(0, 6) != 0, en_b);
					sent += FRAME_PAYLOAD + 4;
				end else begin
					n = $urandom_range(1, 14);
					for (int i = 0; i < n; i++)
						send_byte(byte_t'($urandom), $urandom_range(0, 7) == 0);
					sent += n;
				end
			end
			drain_results();
		end

		byte_if.valid <= 1'b0;
		for (int i = 0; i < 20000 && board.pending() != 0; i++)
			@(negedge clk);
		repeat (8) @(negedge clk);
		while (board.pending() != 0) begin
			void'(board.expected_frames.pop_front());
			board.report("expected result word never arrived");
		end
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
